@@ hw/rtl/irmfd_pkg.sv @@
// Shared types and constants of the infrared Manchester frame decoder.
// No dependencies; every other file of the block refers to this package by scoped names.
package irmfd_pkg;

  localparam int DUR_W           = 16;    // width of one captured duration
  localparam int CODE_W          = 64;    // width of a decoded frame code
  localparam int UNIT_USEC       = 1000;  // quantization unit in microseconds
  localparam int MAX_REPS        = 3;     // repetition codes kept for the vote
  localparam int REP_W           = 2;     // counter width for up to MAX_REPS codes
  localparam int BUFFER_DEPTH_DEF = 256;
  localparam int TICK_USEC_DEF   = 2;

  // Length of one stored entry after rounding to whole units.
  typedef enum logic [2:0] {
    UC_ZERO,
    UC_ONE,
    UC_THREE,
    UC_FOUR,
    UC_OTHER   // two units, or five and more
  } unit_class_t;

  typedef enum logic [2:0] {
    WS_LOAD,
    WS_SCAN_RD,
    WS_SCAN_EV,
    WS_BIT_RD,
    WS_BIT_EV,
    WS_BEND_EV,
    WS_FINAL_EV,
    WS_EMIT
  } walk_state_t;

endpackage

@@ hw/rtl/irmfd_store.sv @@
// Duration store: one write port and two registered read ports.
// Depends on irmfd_pkg for the duration width.
module irmfd_store #(
  parameter int BUFFER_DEPTH = irmfd_pkg::BUFFER_DEPTH_DEF,
  parameter int AW           = $clog2(BUFFER_DEPTH)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [irmfd_pkg::DUR_W-1:0] wr_data,
  input  logic [AW-1:0]               rd_addr_a,
  input  logic [AW-1:0]               rd_addr_b,
  output logic [irmfd_pkg::DUR_W-1:0] rd_data_a,
  output logic [irmfd_pkg::DUR_W-1:0] rd_data_b
);

  logic [irmfd_pkg::DUR_W-1:0] mem [BUFFER_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

@@ hw/rtl/irmfd_quant.sv @@
// Rounds a duration in ticks to whole 1000-microsecond units and classifies it.
// Depends on irmfd_pkg for the unit class type and the unit length.
module irmfd_quant #(
  parameter int TICK_USEC = irmfd_pkg::TICK_USEC_DEF
) (
  input  logic                        valid,
  input  logic [irmfd_pkg::DUR_W-1:0] duration,
  output irmfd_pkg::unit_class_t      unit_class
);

  localparam int PW = irmfd_pkg::DUR_W + $clog2(TICK_USEC + 1) + 1;
  localparam int U  = irmfd_pkg::UNIT_USEC;

  logic [PW-1:0] usec_rounded;

  // Adding half a unit turns round-to-nearest into plain range checks.
  assign usec_rounded = PW'(duration) * PW'(TICK_USEC) + PW'(U / 2);

  always_comb begin
    if (!valid || usec_rounded < PW'(U)) begin
      unit_class = irmfd_pkg::UC_ZERO;
    end else if (usec_rounded < PW'(2 * U)) begin
      unit_class = irmfd_pkg::UC_ONE;
    end else if (usec_rounded >= PW'(3 * U) && usec_rounded < PW'(4 * U)) begin
      unit_class = irmfd_pkg::UC_THREE;
    end else if (usec_rounded >= PW'(4 * U) && usec_rounded < PW'(5 * U)) begin
      unit_class = irmfd_pkg::UC_FOUR;
    end else begin
      unit_class = irmfd_pkg::UC_OTHER;
    end
  end

endmodule

@@ hw/rtl/irmfd_walker.sv @@
// Capture loader and decode sequencer: walks the duration store two entries at a time,
// shortens split halves in place and keeps the repetition codes for the vote.
// Depends on irmfd_pkg and irmfd_quant.
module irmfd_walker #(
  parameter int BUFFER_DEPTH = irmfd_pkg::BUFFER_DEPTH_DEF,
  parameter int TICK_USEC    = irmfd_pkg::TICK_USEC_DEF,
  parameter int AW           = $clog2(BUFFER_DEPTH)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [irmfd_pkg::DUR_W-1:0]  in_duration,
  input  logic                         in_last,
  output logic                         wr_en,
  output logic [AW-1:0]                wr_addr,
  output logic [irmfd_pkg::DUR_W-1:0]  wr_data,
  output logic [AW-1:0]                rd_addr_a,
  output logic [AW-1:0]                rd_addr_b,
  input  logic [irmfd_pkg::DUR_W-1:0]  rd_data_a,
  input  logic [irmfd_pkg::DUR_W-1:0]  rd_data_b,
  output logic                         res_valid,
  input  logic                         res_ready,
  output logic [irmfd_pkg::CODE_W-1:0] res_code
);

  localparam int CW  = $clog2(BUFFER_DEPTH + 1);
  localparam int CW1 = CW + 1;
  localparam int DW  = irmfd_pkg::DUR_W;
  localparam int KW  = irmfd_pkg::REP_W;
  localparam logic [DW-1:0] SHORT_BIT = DW'(irmfd_pkg::UNIT_USEC / TICK_USEC);
  localparam logic [DW-1:0] SHORT_HDR = DW'(3 * irmfd_pkg::UNIT_USEC / TICK_USEC);

  irmfd_pkg::walk_state_t state, state_next;
  logic [CW-1:0]                 fill;
  logic [KW-1:0]                 kept;
  logic [CW-1:0]                 pos;
  logic                          half_space;
  logic [irmfd_pkg::CODE_W-1:0]  acc;
  logic [irmfd_pkg::CODE_W-1:0]  codes [irmfd_pkg::MAX_REPS];
  logic [irmfd_pkg::CODE_W-1:0]  majority;
  logic                          va, vb;
  logic [CW1-1:0]                pos_plus1;
  logic                          pair_in_capture;
  logic                          not_full;
  irmfd_pkg::unit_class_t        qa, qb;
  logic                          qb_long;
  logic                          store_en;
  logic [irmfd_pkg::CODE_W-1:0]  store_val;

  irmfd_quant #(.TICK_USEC(TICK_USEC)) u_quant_a (
    .valid(va), .duration(rd_data_a), .unit_class(qa)
  );
  irmfd_quant #(.TICK_USEC(TICK_USEC)) u_quant_b (
    .valid(vb), .duration(rd_data_b), .unit_class(qb)
  );

  assign pos_plus1       = {1'b0, pos} + CW1'(1);
  assign pair_in_capture = pos_plus1 < {1'b0, fill};
  assign not_full        = fill < CW'(BUFFER_DEPTH);
  assign qb_long         = (qb == irmfd_pkg::UC_THREE) || (qb == irmfd_pkg::UC_FOUR) ||
                           (qb == irmfd_pkg::UC_OTHER);
  assign rd_addr_a       = pos[AW-1:0];
  assign rd_addr_b       = pos_plus1[AW-1:0];

  assign majority = (codes[0] == codes[1] || codes[0] == codes[2]) ? codes[0] :
                    (codes[1] == codes[2]) ? codes[1] : '0;

  // A repetition ends here; only the bit and bit-end evaluations store, and a bit step that continues does not.
  always_comb begin
    store_en  = 1'b0;
    store_val = '0;
    case (state)
      irmfd_pkg::WS_BIT_EV: begin
        store_en = !(qa == irmfd_pkg::UC_ONE && qb != irmfd_pkg::UC_ZERO);
        if (qa == irmfd_pkg::UC_THREE) begin
          store_val = acc;
        end
      end
      irmfd_pkg::WS_BEND_EV: begin
        store_en = 1'b1;
        if (qa == irmfd_pkg::UC_FOUR) begin
          store_val = acc;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      irmfd_pkg::WS_LOAD: begin
        if (in_valid && in_last) state_next = irmfd_pkg::WS_SCAN_RD;
      end
      irmfd_pkg::WS_SCAN_RD: begin
        if (pair_in_capture && kept != KW'(irmfd_pkg::MAX_REPS)) begin
          state_next = irmfd_pkg::WS_SCAN_EV;
        end else begin
          state_next = irmfd_pkg::WS_FINAL_EV;
        end
      end
      irmfd_pkg::WS_SCAN_EV: begin
        if (qa == irmfd_pkg::UC_THREE &&
            (qb == irmfd_pkg::UC_THREE || qb == irmfd_pkg::UC_FOUR)) begin
          state_next = irmfd_pkg::WS_BIT_RD;
        end else begin
          state_next = irmfd_pkg::WS_SCAN_RD;
        end
      end
      irmfd_pkg::WS_BIT_RD: begin
        state_next = pair_in_capture ? irmfd_pkg::WS_BIT_EV : irmfd_pkg::WS_BEND_EV;
      end
      irmfd_pkg::WS_BIT_EV: begin
        state_next = store_en ? irmfd_pkg::WS_SCAN_RD : irmfd_pkg::WS_BIT_RD;
      end
      irmfd_pkg::WS_BEND_EV:  state_next = irmfd_pkg::WS_SCAN_RD;
      irmfd_pkg::WS_FINAL_EV: state_next = irmfd_pkg::WS_EMIT;
      irmfd_pkg::WS_EMIT: begin
        if (res_ready) state_next = irmfd_pkg::WS_LOAD;
      end
      default: state_next = irmfd_pkg::WS_LOAD;
    endcase
  end

  // A shortened entry is written in an evaluate cycle and read back no earlier than
  // the next read cycle, so the store never returns stale data.
  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = pos_plus1[AW-1:0];
    wr_data   = rd_data_b - SHORT_BIT;
    case (state)
      irmfd_pkg::WS_LOAD: begin
        in_ready = 1'b1;
        wr_en    = in_valid && not_full;
        wr_addr  = fill[AW-1:0];
        wr_data  = in_duration;
      end
      irmfd_pkg::WS_SCAN_EV: begin
        wr_en   = qa == irmfd_pkg::UC_THREE && qb == irmfd_pkg::UC_FOUR;
        wr_data = rd_data_b - SHORT_HDR;
      end
      irmfd_pkg::WS_BIT_EV: begin
        wr_en = qa == irmfd_pkg::UC_ONE && qb_long;
      end
      irmfd_pkg::WS_EMIT: res_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= irmfd_pkg::WS_LOAD;
      fill  <= '0;
      kept  <= '0;
    end else begin
      state <= state_next;
      if (state == irmfd_pkg::WS_LOAD && in_valid) begin
        if (not_full) fill <= fill + CW'(1);
        if (in_last) kept <= '0;
      end
      if (store_en) kept <= kept + KW'(1);
      if (state == irmfd_pkg::WS_EMIT && res_ready) fill <= '0;
    end
  end

  always_ff @(posedge clk) begin
    va <= pos < fill;
    vb <= pair_in_capture;
    case (state)
      irmfd_pkg::WS_LOAD: begin
        if (in_valid && in_last) begin
          pos        <= '0;
          half_space <= 1'b0;
          for (int k = 0; k < irmfd_pkg::MAX_REPS; k++) codes[k] <= '0;
        end
      end
      irmfd_pkg::WS_SCAN_EV: begin
        acc <= '0;
        if (qa == irmfd_pkg::UC_THREE && qb == irmfd_pkg::UC_THREE) begin
          pos        <= pos + CW'(2);
          half_space <= 1'b0;
        end else if (qa == irmfd_pkg::UC_THREE && qb == irmfd_pkg::UC_FOUR) begin
          // The long header space carries the first half bit.
          pos        <= pos + CW'(1);
          half_space <= 1'b1;
        end else begin
          pos <= pos + CW'(1);
        end
      end
      irmfd_pkg::WS_BIT_EV: begin
        if (!store_en) begin
          acc <= {acc[irmfd_pkg::CODE_W-2:0], half_space};
          if (qb_long) begin
            half_space <= !half_space;
            pos        <= pos + CW'(1);
          end else begin
            pos <= pos + CW'(2);
          end
        end
      end
      irmfd_pkg::WS_FINAL_EV: begin
        res_code <= (qa == irmfd_pkg::UC_FOUR) ? majority : '0;
      end
      default: ;
    endcase
    if (store_en) codes[kept] <= store_val;
  end

  a_shorten_in_capture: assert property (@(posedge clk) disable iff (rst)
    (wr_en && state != irmfd_pkg::WS_LOAD) |-> vb)
    else $error("shortened entry lies outside the capture");

  a_split_after_one_unit: assert property (@(posedge clk) disable iff (rst)
    (wr_en && state == irmfd_pkg::WS_BIT_EV) |-> qa == irmfd_pkg::UC_ONE)
    else $error("half split without a one-unit half before it");

  a_store_room: assert property (@(posedge clk) disable iff (rst)
    store_en |-> kept != KW'(irmfd_pkg::MAX_REPS))
    else $error("repetition code stored with all slots taken");

  a_fill_cleared: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_ready) |=> (fill == '0 && state == irmfd_pkg::WS_LOAD))
    else $error("capture not cleared after the result request");

endmodule

@@ hw/rtl/ir_manchester_frame_decoder.sv @@
// Infrared Manchester frame decoder. Each input request carries one captured mark or
// space length in ticks (tlast on the final one); while loading, lengths are stored at one
// per cycle, and requests beyond BUFFER_DEPTH entries are dropped except that a final one
// still starts decoding. The final request starts a walk over the stored train in steps of
// one registered read of two neighboring entries and then one evaluation that may shorten
// an entry in place. Input is not taken during the walk or while the result waits to be
// handed to the output register. The result is the majority of up to three repetition
// codes, or zero, and sits in an output register so the next capture can be loaded while
// it waits to be taken.
// Depends on irmfd_pkg, irmfd_store, irmfd_walker and irmfd_quant.
module ir_manchester_frame_decoder #(
  parameter int BUFFER_DEPTH = irmfd_pkg::BUFFER_DEPTH_DEF,
  parameter int TICK_USEC    = irmfd_pkg::TICK_USEC_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [irmfd_pkg::DUR_W-1:0]  s_tdata,   // [15:0] duration
  input  logic                         s_tlast,   // last_item
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [irmfd_pkg::CODE_W-1:0] m_tdata    // [63:0] code
);

  localparam int AW = $clog2(BUFFER_DEPTH);

  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  logic [irmfd_pkg::DUR_W-1:0]  wr_data;
  logic [AW-1:0]                rd_addr_a, rd_addr_b;
  logic [irmfd_pkg::DUR_W-1:0]  rd_data_a, rd_data_b;
  logic                         res_valid, res_ready;
  logic [irmfd_pkg::CODE_W-1:0] res_code;

  irmfd_store #(.BUFFER_DEPTH(BUFFER_DEPTH), .AW(AW)) u_store (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr_a(rd_addr_a), .rd_addr_b(rd_addr_b),
    .rd_data_a(rd_data_a), .rd_data_b(rd_data_b)
  );

  irmfd_walker #(.BUFFER_DEPTH(BUFFER_DEPTH), .TICK_USEC(TICK_USEC), .AW(AW)) u_walker (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready), .in_duration(s_tdata), .in_last(s_tlast),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr_a(rd_addr_a), .rd_addr_b(rd_addr_b),
    .rd_data_a(rd_data_a), .rd_data_b(rd_data_b),
    .res_valid(res_valid), .res_ready(res_ready), .res_code(res_code)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= res_code;
    end
  end

endmodule
